// ----- src/kbf_pkg.sv -----
// Shared types and constants for the canonical k-mer Bloom filter.
package kbf_pkg;

    // Configuration register indexes.
    localparam logic REG_KMER_LENGTH = 1'b0;
    localparam logic REG_NUM_HASHES  = 1'b1;

    localparam logic [5:0] KMER_LENGTH_RESET = 6'd21;
    localparam logic [3:0] NUM_HASHES_RESET  = 4'd5;
    localparam logic [5:0] MAX_KMER          = 6'd32;
    localparam logic [3:0] MAX_HASHES        = 4'd8;
    localparam logic [7:0] PACK_OFFSET       = 8'd32;
    localparam logic [63:0] SEED_BASE        = 64'd17;

    // MurmurHash3 x64_128 constants.
    localparam logic [63:0] MM_C1  = 64'h87c37b91114253d5;
    localparam logic [63:0] MM_C2  = 64'h4cf5ad432745937f;
    localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_CANON,
        S_PACK,
        S_K2A,
        S_K2B,
        S_K1A,
        S_K1B,
        S_SEED,
        S_ADD1,
        S_ADD2,
        S_H1A,
        S_H1B,
        S_H1X,
        S_H2A,
        S_H2B,
        S_H2X,
        S_FIN,
        S_MOD,
        S_MQ,
        S_MP,
        S_MC,
        S_PROBE,
        S_CHECK,
        S_WRD,
        S_WWR,
        S_DONE
    } kbf_state_t;

endpackage

// ----- src/kbf_mul64.sv -----
// Shared 64x64 low-half multiplier: one 32x32 multiplier reused per partial product.
module kbf_mul64 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] product
);

    logic [1:0]  phase_reg, phase_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] op_a, op_b;
    logic [63:0] m;

    always_comb
    begin
        case (phase_reg)
            2'd0:
            begin
                op_a = a[31:0];
                op_b = b[31:0];
            end
            2'd1:
            begin
                op_a = a[31:0];
                op_b = b[63:32];
            end
            default:
            begin
                op_a = a[63:32];
                op_b = b[31:0];
            end
        endcase
    end

    assign m = 64'(op_a) * 64'(op_b);

    // The last cross product is folded in on the way out.
    assign done    = go && (phase_reg == 2'd2);
    assign product = {acc_reg[63:32] + m[31:0], acc_reg[31:0]};

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        if (go)
        begin
            case (phase_reg)
                2'd0:
                begin
                    acc_next   = m;
                    phase_next = 2'd1;
                end
                2'd1:
                begin
                    acc_next   = {acc_reg[63:32] + m[31:0], acc_reg[31:0]};
                    phase_next = 2'd2;
                end
                default:
                begin
                    phase_next = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

endmodule

// ----- src/kbf_table.sv -----
// Bit table memory: one write port and one registered read port, 64-bit words.
module kbf_table #(
    parameter int TABLE_WORDS = 4096,
    parameter int AW          = 12
) (
    input  logic          clk,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [63:0]   wr_data,
    output logic [63:0]   rd_data
);

    logic [63:0] mem [TABLE_WORDS];
    logic [63:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/canonical_kmer_bloom_filter.sv -----
// Canonical k-mer Bloom filter top level: sequencer, hash datapath and probe logic.
// Per probe the hash is mixed and reduced to a table position; a table size that is not a
// power of two adds a chunked remainder, and a write pass follows when bits are inserted.
// Requests: one at a time; busy stays high through the result strobe, and the
// multiplier is shared by the hash and remainder steps. The receiver cannot stall.
// Reset: control and config registers return to defaults and a clearing pass zeroes the table.
module canonical_kmer_bloom_filter #(
    parameter int TABLE_WORDS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] kmer_bases,
    output logic        done,
    output logic        seen_before,
    output logic [63:0] canonical_kmer,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_data
);

    // Word address width, and remainder width for a probe position in the whole table.
    localparam int AW        = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1;
    localparam int REM_W     = AW + 6;
    localparam bit SPAN_POW2 = ((TABLE_WORDS & (TABLE_WORDS - 1)) == 0);
    localparam logic [63:0] TW_64   = 64'(TABLE_WORDS);
    localparam logic [63:0] TW_MASK = 64'(TABLE_WORDS - 1);
    // Reciprocal of the word count for the chunked remainder; 16 bits are folded per step.
    localparam int          DIV_S = AW + 16;
    localparam logic [63:0] RECIP = (64'd1 << DIV_S) / TW_64;

    kbf_pkg::kbf_state_t state_reg, state_next;

    logic [5:0]  klen_cfg_reg;
    logic [3:0]  nh_cfg_reg;

    logic [5:0]  k_reg, k_next;
    logic [3:0]  nh_reg, nh_next;
    logic [63:0] fwd_reg, fwd_next;
    logic [63:0] canon_reg, canon_next;
    logic [3:0]  plen_reg, plen_next;
    logic [63:0] k1_reg, k1_next;
    logic [63:0] k2_reg, k2_next;
    logic [63:0] h1_reg, h1_next;
    logic [63:0] h2_reg, h2_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [63:0] y_reg, y_next;
    logic [63:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [3:0]  probe_reg, probe_next;
    logic        all_set_reg, all_set_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] widx_reg [8];
    logic [5:0]    bidx_reg [8];

    // Shared multiplier.
    logic        mul_go, mul_done;
    logic [63:0] mul_a, mul_b, mul_p;

    // Table port.
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    logic [63:0]   wr_data, rd_data;

    logic [5:0]    k_clamped;
    logic [3:0]    nh_clamped;
    logic [63:0]   kmask;
    logic [63:0]   rc_full, rc;
    logic [63:0]   cl;
    logic [65:0]   cl_ext;
    logic [7:0]    pbytes [11];
    logic [12:0]   plen_prod;
    logic [3:0]    plen_calc;
    logic [63:0]   mod_v;
    logic [15:0]   mod_chunk;
    logic [63:0]   mod_fix;
    logic [AW-1:0] rem_word;
    logic [2:0]    p_idx;
    logic          last_probe;

    kbf_mul64 u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (mul_go),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    kbf_table #(
        .TABLE_WORDS (TABLE_WORDS),
        .AW          (AW)
    ) u_table (
        .clk     (clk),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    // Configuration registers are taken at any time; the datapath latches clamped copies
    // when a request starts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            klen_cfg_reg <= kbf_pkg::KMER_LENGTH_RESET;
            nh_cfg_reg   <= kbf_pkg::NUM_HASHES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                kbf_pkg::REG_KMER_LENGTH: klen_cfg_reg <= cfg_data;
                kbf_pkg::REG_NUM_HASHES:  nh_cfg_reg   <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // A zero length or probe count means one; anything over the maximum saturates.
    always_comb
    begin
        if (klen_cfg_reg == 6'd0)
        begin
            k_clamped = 6'd1;
        end
        else if (klen_cfg_reg > kbf_pkg::MAX_KMER)
        begin
            k_clamped = kbf_pkg::MAX_KMER;
        end
        else
        begin
            k_clamped = klen_cfg_reg;
        end

        if (nh_cfg_reg == 4'd0)
        begin
            nh_clamped = 4'd1;
        end
        else if (nh_cfg_reg > kbf_pkg::MAX_HASHES)
        begin
            nh_clamped = kbf_pkg::MAX_HASHES;
        end
        else
        begin
            nh_clamped = nh_cfg_reg;
        end
    end

    assign kmask = (k_clamped == kbf_pkg::MAX_KMER) ? '1
                 : ((64'd1 << {k_clamped, 1'b0}) - 64'd1);

    // Reverse complement: swap the base order of the complemented word, then drop the
    // unused pairs, which land in the low end after the swap.
    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            rc_full[2*(31-i) +: 2] = ~fwd_reg[2*i +: 2];
        end
    end

    assign rc = rc_full >> (7'd64 - {k_reg, 1'b0});

    // Left-justify the canonical k-mer so that each packed byte comes from a fixed slice.
    assign cl     = canon_reg << (7'd64 - {k_reg, 1'b0});
    assign cl_ext = {cl, 2'b00};

    // Packed length (k + 2) / 3 by reciprocal multiplication; exact for k up to 32.
    assign plen_prod = ((13'(k_reg) + 13'd2) * 13'd171) >> 9;
    assign plen_calc = plen_prod[3:0];

    always_comb
    begin
        for (int x = 0; x < 11; x++)
        begin
            if (4'(x) < plen_calc)
            begin
                pbytes[x] = kbf_pkg::PACK_OFFSET + {2'b00, cl_ext[65 - 6*x -: 6]};
            end
            else
            begin
                pbytes[x] = 8'd0;
            end
        end
    end

    // The word index is (h1 >> 6) mod TABLE_WORDS; for a size that is not a power of two it
    // is folded in 16-bit chunks from the top. Each fold estimates the quotient by reciprocal
    // multiplication, short by at most one, so a single compare and subtract finishes the step.
    assign mod_v     = h1_reg >> 6;
    assign mod_chunk = 16'(mod_v >> {~cnt_reg[1:0], 4'b0000});
    assign mod_fix   = (y_reg >= TW_64) ? (y_reg - TW_64) : y_reg;

    assign rem_word   = AW'(rem_reg >> 6);
    assign p_idx      = probe_reg[2:0];
    assign last_probe = ((probe_reg + 4'd1) == nh_reg);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kbf_pkg::S_CLEAR:
            begin
                if (clr_reg == AW'(TABLE_WORDS - 1))
                begin
                    state_next = kbf_pkg::S_IDLE;
                end
            end
            kbf_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = kbf_pkg::S_CANON;
                end
            end
            kbf_pkg::S_CANON: state_next = kbf_pkg::S_PACK;
            kbf_pkg::S_PACK:  state_next = kbf_pkg::S_K2A;
            kbf_pkg::S_K2A:   if (mul_done) state_next = kbf_pkg::S_K2B;
            kbf_pkg::S_K2B:   if (mul_done) state_next = kbf_pkg::S_K1A;
            kbf_pkg::S_K1A:   if (mul_done) state_next = kbf_pkg::S_K1B;
            kbf_pkg::S_K1B:   if (mul_done) state_next = kbf_pkg::S_SEED;
            kbf_pkg::S_SEED:  state_next = kbf_pkg::S_ADD1;
            kbf_pkg::S_ADD1:  state_next = kbf_pkg::S_ADD2;
            kbf_pkg::S_ADD2:  state_next = kbf_pkg::S_H1A;
            kbf_pkg::S_H1A:   if (mul_done) state_next = kbf_pkg::S_H1B;
            kbf_pkg::S_H1B:   if (mul_done) state_next = kbf_pkg::S_H1X;
            kbf_pkg::S_H1X:   state_next = kbf_pkg::S_H2A;
            kbf_pkg::S_H2A:   if (mul_done) state_next = kbf_pkg::S_H2B;
            kbf_pkg::S_H2B:   if (mul_done) state_next = kbf_pkg::S_H2X;
            kbf_pkg::S_H2X:   state_next = kbf_pkg::S_FIN;
            kbf_pkg::S_FIN:   state_next = kbf_pkg::S_MOD;
            kbf_pkg::S_MOD:
            begin
                if (SPAN_POW2)
                begin
                    state_next = kbf_pkg::S_PROBE;
                end
                else
                begin
                    state_next = kbf_pkg::S_MQ;
                end
            end
            kbf_pkg::S_MQ:    if (mul_done) state_next = kbf_pkg::S_MP;
            kbf_pkg::S_MP:    if (mul_done) state_next = kbf_pkg::S_MC;
            kbf_pkg::S_MC:
            begin
                if (cnt_reg == 6'd3)
                begin
                    state_next = kbf_pkg::S_PROBE;
                end
                else
                begin
                    state_next = kbf_pkg::S_MOD;
                end
            end
            kbf_pkg::S_PROBE: state_next = kbf_pkg::S_CHECK;
            kbf_pkg::S_CHECK:
            begin
                if (!last_probe)
                begin
                    state_next = kbf_pkg::S_SEED;
                end
                else if (all_set_reg && rd_data[bidx_reg[p_idx]])
                begin
                    state_next = kbf_pkg::S_DONE;
                end
                else
                begin
                    state_next = kbf_pkg::S_WRD;
                end
            end
            kbf_pkg::S_WRD:   state_next = kbf_pkg::S_WWR;
            kbf_pkg::S_WWR:
            begin
                if (last_probe)
                begin
                    state_next = kbf_pkg::S_DONE;
                end
                else
                begin
                    state_next = kbf_pkg::S_WRD;
                end
            end
            kbf_pkg::S_DONE:  state_next = kbf_pkg::S_IDLE;
            default:          state_next = kbf_pkg::S_IDLE;
        endcase
    end

    // Datapath and port outputs.
    always_comb
    begin
        k_next       = k_reg;
        nh_next      = nh_reg;
        fwd_next     = fwd_reg;
        canon_next   = canon_reg;
        plen_next    = plen_reg;
        k1_next      = k1_reg;
        k2_next      = k2_reg;
        h1_next      = h1_reg;
        h2_next      = h2_reg;
        rem_next     = rem_reg;
        y_next       = y_reg;
        q_next       = q_reg;
        cnt_next     = cnt_reg;
        probe_next   = probe_reg;
        all_set_next = all_set_reg;
        clr_next     = clr_reg;
        mul_go       = 1'b0;
        mul_a        = k2_reg;
        mul_b        = kbf_pkg::MM_C2;
        rd_addr      = widx_reg[p_idx];
        wr_en        = 1'b0;
        wr_addr      = widx_reg[p_idx];
        wr_data      = rd_data | (64'd1 << bidx_reg[p_idx]);

        unique case (state_reg)
            kbf_pkg::S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = 64'd0;
                clr_next = clr_reg + AW'(1);
            end
            kbf_pkg::S_IDLE:
            begin
                k_next   = k_clamped;
                nh_next  = nh_clamped;
                fwd_next = kmer_bases & kmask;
            end
            kbf_pkg::S_CANON:
            begin
                // Ties keep the forward strand.
                canon_next = (fwd_reg <= rc) ? fwd_reg : rc;
            end
            kbf_pkg::S_PACK:
            begin
                plen_next    = plen_calc;
                k1_next      = {pbytes[7], pbytes[6], pbytes[5], pbytes[4],
                                pbytes[3], pbytes[2], pbytes[1], pbytes[0]};
                k2_next      = {40'd0, pbytes[10], pbytes[9], pbytes[8]};
                probe_next   = 4'd0;
                all_set_next = 1'b1;
            end
            kbf_pkg::S_K2A:
            begin
                mul_go = 1'b1;
                if (mul_done) k2_next = mul_p;
            end
            kbf_pkg::S_K2B:
            begin
                mul_go = 1'b1;
                mul_a  = {k2_reg[30:0], k2_reg[63:31]};
                mul_b  = kbf_pkg::MM_C1;
                if (mul_done) k2_next = mul_p;
            end
            kbf_pkg::S_K1A:
            begin
                mul_go = 1'b1;
                mul_a  = k1_reg;
                mul_b  = kbf_pkg::MM_C1;
                if (mul_done) k1_next = mul_p;
            end
            kbf_pkg::S_K1B:
            begin
                mul_go = 1'b1;
                mul_a  = {k1_reg[32:0], k1_reg[63:33]};
                mul_b  = kbf_pkg::MM_C2;
                if (mul_done) k1_next = mul_p;
            end
            kbf_pkg::S_SEED:
            begin
                // An empty high block mixes to zero, so it needs no special handling.
                h1_next = (kbf_pkg::SEED_BASE + 64'(probe_reg)) ^ k1_reg ^ 64'(plen_reg);
                h2_next = (kbf_pkg::SEED_BASE + 64'(probe_reg)) ^ k2_reg ^ 64'(plen_reg);
            end
            kbf_pkg::S_ADD1:
            begin
                h1_next = h1_reg + h2_reg;
            end
            kbf_pkg::S_ADD2:
            begin
                h2_next = h2_reg + h1_reg;
            end
            kbf_pkg::S_H1A:
            begin
                mul_go = 1'b1;
                mul_a  = h1_reg ^ (h1_reg >> 33);
                mul_b  = kbf_pkg::MIX_C1;
                if (mul_done) h1_next = mul_p;
            end
            kbf_pkg::S_H1B:
            begin
                mul_go = 1'b1;
                mul_a  = h1_reg ^ (h1_reg >> 33);
                mul_b  = kbf_pkg::MIX_C2;
                if (mul_done) h1_next = mul_p;
            end
            kbf_pkg::S_H1X:
            begin
                h1_next = h1_reg ^ (h1_reg >> 33);
            end
            kbf_pkg::S_H2A:
            begin
                mul_go = 1'b1;
                mul_a  = h2_reg ^ (h2_reg >> 33);
                mul_b  = kbf_pkg::MIX_C1;
                if (mul_done) h2_next = mul_p;
            end
            kbf_pkg::S_H2B:
            begin
                mul_go = 1'b1;
                mul_a  = h2_reg ^ (h2_reg >> 33);
                mul_b  = kbf_pkg::MIX_C2;
                if (mul_done) h2_next = mul_p;
            end
            kbf_pkg::S_H2X:
            begin
                h2_next = h2_reg ^ (h2_reg >> 33);
            end
            kbf_pkg::S_FIN:
            begin
                h1_next  = h1_reg + h2_reg;
                rem_next = '0;
                cnt_next = 6'd0;
            end
            kbf_pkg::S_MOD:
            begin
                if (SPAN_POW2)
                begin
                    rem_next = {AW'((h1_reg >> 6) & TW_MASK), h1_reg[5:0]};
                end
                else
                begin
                    y_next = (64'(rem_word) << 16) | 64'(mod_chunk);
                end
            end
            kbf_pkg::S_MQ:
            begin
                mul_go = 1'b1;
                mul_a  = y_reg;
                mul_b  = RECIP;
                if (mul_done) q_next = mul_p >> DIV_S;
            end
            kbf_pkg::S_MP:
            begin
                mul_go = 1'b1;
                mul_a  = q_reg;
                mul_b  = TW_64;
                if (mul_done) y_next = y_reg - mul_p;
            end
            kbf_pkg::S_MC:
            begin
                rem_next = {AW'(mod_fix), h1_reg[5:0]};
                cnt_next = cnt_reg + 6'd1;
            end
            kbf_pkg::S_PROBE:
            begin
                rd_addr = rem_word;
            end
            kbf_pkg::S_CHECK:
            begin
                all_set_next = all_set_reg && rd_data[bidx_reg[p_idx]];
                probe_next   = last_probe ? 4'd0 : (probe_reg + 4'd1);
            end
            kbf_pkg::S_WRD:
            begin
                rd_addr = widx_reg[p_idx];
            end
            kbf_pkg::S_WWR:
            begin
                wr_en      = 1'b1;
                probe_next = probe_reg + 4'd1;
            end
            kbf_pkg::S_DONE: ;
            default: ;
        endcase
    end

    assign busy           = (state_reg != kbf_pkg::S_IDLE);
    assign done           = (state_reg == kbf_pkg::S_DONE);
    assign seen_before    = all_set_reg;
    assign canonical_kmer = canon_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= kbf_pkg::S_CLEAR;
            clr_reg     <= '0;
            probe_reg   <= 4'd0;
            cnt_reg     <= 6'd0;
            all_set_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            probe_reg   <= probe_next;
            cnt_reg     <= cnt_next;
            all_set_reg <= all_set_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        nh_reg    <= nh_next;
        fwd_reg   <= fwd_next;
        canon_reg <= canon_next;
        plen_reg  <= plen_next;
        k1_reg    <= k1_next;
        k2_reg    <= k2_next;
        h1_reg    <= h1_next;
        h2_reg    <= h2_next;
        rem_reg   <= rem_next;
        y_reg     <= y_next;
        q_reg     <= q_next;
        if (state_reg == kbf_pkg::S_PROBE)
        begin
            widx_reg[p_idx] <= rem_word;
            bidx_reg[p_idx] <= rem_reg[5:0];
        end
    end

endmodule
